// ===== design/abr_pkg.sv =====
package abr_pkg;

  localparam int PIX_W      = 16;
  localparam int ADDR_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int STRIDE_W   = 11;
  localparam int POS_W      = 10;
  localparam int DIM_W      = 11;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_STRIDE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LEFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_TOP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 3'd7;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd480;
  localparam logic [DIM_W-1:0]    DIM_RESET    = 11'd1;

  // floor(x/15) == (x*RECIP_15) >> RECIP_SHIFT for every x below 4096
  localparam logic [11:0] RECIP_15    = 12'd2185;
  localparam int          RECIP_SHIFT = 15;

  typedef struct packed {
    logic [STRIDE_W-1:0] dest_stride;
    logic [POS_W-1:0]    dest_left;
    logic [POS_W-1:0]    dest_top;
    logic [STRIDE_W-1:0] source_stride;
    logic [POS_W-1:0]    source_left;
    logic [POS_W-1:0]    source_top;
    logic [DIM_W-1:0]    rect_width;
    logic [DIM_W-1:0]    rect_height;
  } cfg_t;

endpackage

// ===== design/abr_pix_if.sv =====
interface abr_pix_if import abr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] fg_pixel;
  logic [PIX_W-1:0] bg_pixel;

  modport source (output valid, output fg_pixel, output bg_pixel, input ready);
  modport sink   (input valid, input fg_pixel, input bg_pixel, output ready);
endinterface

// ===== design/abr_res_if.sv =====
interface abr_res_if import abr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  blended_pixel;
  logic [ADDR_W-1:0] dest_address;
  logic [ADDR_W-1:0] source_address;
  logic              last_pixel;

  modport source (output valid, output blended_pixel, output dest_address,
                  output source_address, output last_pixel, input ready);
  modport sink   (input valid, input blended_pixel, input dest_address,
                  input source_address, input last_pixel, output ready);
endinterface

// ===== design/abr_cfg_if.sv =====
interface abr_cfg_if import abr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/abr_cfg_regs.sv =====
module abr_cfg_regs import abr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  abr_cfg_if.sink   cfg,
  output cfg_t      regs,
  output logic      clear
);

  logic write;

  assign cfg.ready = 1'b1;
  assign write     = cfg.valid && cfg.ready;
  // every listed register restarts the rectangle
  assign clear     = write;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dest_stride   <= STRIDE_RESET;
      regs.dest_left     <= '0;
      regs.dest_top      <= '0;
      regs.source_stride <= STRIDE_RESET;
      regs.source_left   <= '0;
      regs.source_top    <= '0;
      regs.rect_width    <= DIM_RESET;
      regs.rect_height   <= DIM_RESET;
    end else if (write) begin
      unique case (cfg.index)
        REG_DEST_STRIDE:   regs.dest_stride   <= cfg.data[STRIDE_W-1:0];
        REG_DEST_LEFT:     regs.dest_left     <= cfg.data[POS_W-1:0];
        REG_DEST_TOP:      regs.dest_top      <= cfg.data[POS_W-1:0];
        REG_SOURCE_STRIDE: regs.source_stride <= cfg.data[STRIDE_W-1:0];
        REG_SOURCE_LEFT:   regs.source_left   <= cfg.data[POS_W-1:0];
        REG_SOURCE_TOP:    regs.source_top    <= cfg.data[POS_W-1:0];
        REG_RECT_WIDTH:    regs.rect_width    <= cfg.data[DIM_W-1:0];
        REG_RECT_HEIGHT:   regs.rect_height   <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/abr_raster.sv =====
module abr_raster import abr_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       step,
  input  logic [DIM_W-1:0]           rect_width,
  input  logic [DIM_W-1:0]           rect_height,
  output logic [$clog2(MAX_DIM)-1:0] col,
  output logic [$clog2(MAX_DIM)-1:0] row,
  output logic                       last
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int CMPW = (DW > DIM_W) ? DW : DIM_W;
  localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_DIM);
  localparam logic [CMPW-1:0] ONE_C = CMPW'(1);

  logic [CMPW-1:0] w, h, w_raw, h_raw, col_inc, row_inc;
  logic            col_end, row_end;
  logic [CW-1:0]   col_next, row_next;

  always_comb begin
    w_raw = CMPW'(rect_width);
    h_raw = CMPW'(rect_height);
    if (w_raw == '0)        w = ONE_C;
    else if (w_raw > MAX_C) w = MAX_C;
    else                    w = w_raw;
    if (h_raw == '0)        h = ONE_C;
    else if (h_raw > MAX_C) h = MAX_C;
    else                    h = h_raw;

    col_inc = CMPW'(col) + ONE_C;
    row_inc = CMPW'(row) + ONE_C;
    col_end = col_inc >= w;
    row_end = row_inc >= h;
    last    = col_end && row_end;

    col_next = col_end ? '0 : col_inc[CW-1:0];
    row_next = !col_end ? row : (row_end ? '0 : row_inc[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

// ===== design/abr_blend.sv =====
module abr_blend import abr_pkg::*; (
  input  logic [PIX_W-1:0] fg,
  input  logic [PIX_W-1:0] bg,
  output logic [PIX_W-1:0] pixel
);

  // (f*a + b*(15-a)) / 15, numerator fits 10 bits
  function automatic logic [5:0] mix(input logic [5:0] f, input logic [5:0] b,
                                     input logic [3:0] a);
    logic [9:0]  num;
    logic [21:0] prod;
    num  = ({4'b0, f} * {6'b0, a}) + ({4'b0, b} * {6'b0, 4'hF - a});
    prod = {12'b0, num} * {10'b0, RECIP_15};
    return prod[RECIP_SHIFT +: 6];
  endfunction

  logic [3:0] alpha;
  logic [5:0] r, g, b;

  always_comb begin
    alpha = fg[15:12];
    r = mix({1'b0, fg[11:8], 1'b0}, {1'b0, bg[15:11]}, alpha);
    g = mix({fg[7:4], 2'b00}, bg[10:5], alpha);
    b = mix({1'b0, fg[3:0], 1'b0}, {1'b0, bg[4:0]}, alpha);
    pixel = {r[4:0], g, b[4:0]};
  end

endmodule

// ===== design/abr_addr.sv =====
module abr_addr import abr_pkg::*; #(
  parameter int CW = 10
) (
  input  logic [STRIDE_W-1:0] stride,
  input  logic [POS_W-1:0]    left,
  input  logic [POS_W-1:0]    top,
  input  logic [CW-1:0]       col,
  input  logic [CW-1:0]       row,
  output logic [ADDR_W-1:0]   address
);

  localparam int SW = ((POS_W > CW) ? POS_W : CW) + 1;
  localparam int PW = SW + STRIDE_W;

  logic [SW-1:0] row_abs, col_abs;
  logic [PW-1:0] prod;

  always_comb begin
    row_abs = SW'(top) + SW'(row);
    col_abs = SW'(left) + SW'(col);
    prod    = PW'(row_abs) * PW'(stride);
    // wraps modulo the address space
    address = ADDR_W'(prod) + ADDR_W'(col_abs);
  end

endmodule

// ===== design/argb4444_rgb565_blend_rect.sv =====
// ARGB4444-over-RGB565 rectangle blend, raster order.
// Pixels pass through the input register, then the result register; one
// multiply-add per address. Throughput: one pixel per cycle while results drain;
// a stalled result holds the input register once full.
// Reset (synchronous): pipeline emptied, raster counters cleared, registers
// return to their reset values. Any register write restarts the rectangle.
module argb4444_rgb565_blend_rect import abr_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic      clk,
  input  logic      rst,
  abr_cfg_if.sink   cfg,
  abr_pix_if.sink   pix_in,
  abr_res_if.source res_out
);

  localparam int CW = $clog2(MAX_DIM);

  cfg_t             regs;
  logic             clear;
  logic             accept, s2_adv;
  logic [CW-1:0]    col, row;
  logic             last;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_fg, s1_bg;
  logic [CW-1:0]    s1_col, s1_row;
  logic             s1_last;

  logic [PIX_W-1:0]  pixel;
  logic [ADDR_W-1:0] daddr, saddr;

  abr_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .regs  (regs),
    .clear (clear)
  );

  abr_raster #(.MAX_DIM(MAX_DIM)) u_raster (
    .clk         (clk),
    .rst         (rst),
    .clear       (clear),
    .step        (accept),
    .rect_width  (regs.rect_width),
    .rect_height (regs.rect_height),
    .col         (col),
    .row         (row),
    .last        (last)
  );

  assign s2_adv       = !res_out.valid || res_out.ready;
  assign pix_in.ready = !s1_valid || s2_adv;
  assign accept       = pix_in.valid && pix_in.ready;

  abr_blend u_blend (
    .fg    (s1_fg),
    .bg    (s1_bg),
    .pixel (pixel)
  );

  abr_addr #(.CW(CW)) u_daddr (
    .stride  (regs.dest_stride),
    .left    (regs.dest_left),
    .top     (regs.dest_top),
    .col     (s1_col),
    .row     (s1_row),
    .address (daddr)
  );

  abr_addr #(.CW(CW)) u_saddr (
    .stride  (regs.source_stride),
    .left    (regs.source_left),
    .top     (regs.source_top),
    .col     (s1_col),
    .row     (s1_row),
    .address (saddr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      res_out.valid <= 1'b0;
    end else begin
      if (pix_in.ready) s1_valid <= pix_in.valid;
      if (s2_adv)       res_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_fg   <= pix_in.fg_pixel;
      s1_bg   <= pix_in.bg_pixel;
      s1_col  <= col;
      s1_row  <= row;
      s1_last <= last;
    end
    if (s2_adv && s1_valid) begin
      res_out.blended_pixel  <= pixel;
      res_out.dest_address   <= daddr;
      res_out.source_address <= saddr;
      res_out.last_pixel     <= s1_last;
    end
  end

endmodule

// ===== dv/blend_rect_checker.sv =====
module blend_rect_checker import abr_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic clk,
  input  logic rst,
  abr_cfg_if   cfg,
  abr_pix_if   pix,
  abr_res_if   res,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] dest_addr;
    logic [ADDR_W-1:0] src_addr;
    logic              last;
  } pixel_write_t;

  cfg_t         regs;
  int           col;
  int           row;
  int           errs;
  pixel_write_t writes_due[$];

  function automatic int dim_limit(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned channel_mix(int unsigned f, int unsigned bk, int unsigned a);
    return (f * a + bk * (15 - a)) / 15;
  endfunction

  // fg channels widened to 565 before the mix; quotient truncates
  function automatic logic [PIX_W-1:0] blend_rgb565(logic [PIX_W-1:0] fg, logic [PIX_W-1:0] bg);
    int unsigned a, r, g, b;
    a = fg[15:12];
    r = channel_mix({fg[11:8], 1'b0}, bg[15:11], a);
    g = channel_mix({fg[7:4], 2'b00}, bg[10:5], a);
    b = channel_mix({fg[3:0], 1'b0}, bg[4:0], a);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic logic [ADDR_W-1:0] raster_address(int unsigned top, int unsigned left,
                                                       int unsigned stride, int unsigned r,
                                                       int unsigned c);
    int unsigned a;
    a = (top + r) * stride + left + c;
    return a[ADDR_W-1:0];
  endfunction

  always @(posedge clk) begin
    pixel_write_t want, got;
    int w, h;
    if (rst) begin
      regs = '{dest_stride: STRIDE_RESET, source_stride: STRIDE_RESET,
               rect_width: DIM_RESET, rect_height: DIM_RESET, default: '0};
      col = 0;
      row = 0;
      writes_due.delete();
    end else begin
      // retire first: a pixel taken this edge cannot show up at this edge
      if (res.valid && res.ready) begin
        got = '{res.blended_pixel, res.dest_address, res.source_address, res.last_pixel};
        if (writes_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected write px=%h da=%h sa=%h last=%b", $realtime,
                     got.pixel, got.dest_addr, got.src_addr, got.last);
        end else begin
          want = writes_due.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display("%0t: write mismatch exp px=%h da=%h sa=%h last=%b, got px=%h da=%h sa=%h last=%b",
                       $realtime, want.pixel, want.dest_addr, want.src_addr, want.last,
                       got.pixel, got.dest_addr, got.src_addr, got.last);
          end
        end
      end

      if (pix.valid && pix.ready) begin
        w = dim_limit(regs.rect_width);
        h = dim_limit(regs.rect_height);
        want.pixel     = blend_rgb565(pix.fg_pixel, pix.bg_pixel);
        want.dest_addr = raster_address(regs.dest_top, regs.dest_left, regs.dest_stride,
                                        row, col);
        want.src_addr  = raster_address(regs.source_top, regs.source_left,
                                        regs.source_stride, row, col);
        want.last      = 1'b0;
        if (col + 1 >= w) begin
          col = 0;
          if (row + 1 >= h) begin
            row = 0;
            want.last = 1'b1;
          end else begin
            row++;
          end
        end else begin
          col++;
        end
        writes_due.push_back(want);
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DEST_STRIDE:   regs.dest_stride   = cfg.data;
          REG_DEST_LEFT:     regs.dest_left     = cfg.data[POS_W-1:0];
          REG_DEST_TOP:      regs.dest_top      = cfg.data[POS_W-1:0];
          REG_SOURCE_STRIDE: regs.source_stride = cfg.data;
          REG_SOURCE_LEFT:   regs.source_left   = cfg.data[POS_W-1:0];
          REG_SOURCE_TOP:    regs.source_top    = cfg.data[POS_W-1:0];
          REG_RECT_WIDTH:    regs.rect_width    = cfg.data;
          REG_RECT_HEIGHT:   regs.rect_height   = cfg.data;
        endcase
        // any register write restarts the rectangle
        col = 0;
        row = 0;
      end
    end
    mismatches  <= errs;
    outstanding <= writes_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import abr_pkg::*;

  localparam int MAX_DIM = 1024;

  logic clk = 1'b0;
  logic rst;
  bit   src_gaps;
  bit   sink_gaps;
  int   mismatches;
  int   outstanding;
  int   cur_w;
  int   cur_h;

  abr_cfg_if cfg_ch ();
  abr_pix_if pix_ch ();
  abr_res_if res_ch ();

  argb4444_rgb565_blend_rect #(.MAX_DIM(MAX_DIM)) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pix_in  (pix_ch),
    .res_out (res_ch)
  );

  blend_rect_checker #(.MAX_DIM(MAX_DIM)) blend_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .pix         (pix_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  // write sink: random stall before each transaction
  initial begin
    int stall;
    forever begin
      stall = sink_gaps ? $urandom_range(0, 12) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 11'h3FF;
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_stride();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 11'd1;
      2:       return 11'h7FF;
      3:       return 11'd1024;
      default: return 11'($urandom_range(1, 2047));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 11'd1;
      8, 9:    return 11'($urandom_range(7, 24));
      default: return 11'($urandom_range(1, 6));
    endcase
  endfunction

  // block is idle once nothing is due and the pipeline has drained
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic program_rect(logic [CFG_DATA_W-1:0] ds, logic [CFG_DATA_W-1:0] dl,
                              logic [CFG_DATA_W-1:0] dt, logic [CFG_DATA_W-1:0] ss,
                              logic [CFG_DATA_W-1:0] sl, logic [CFG_DATA_W-1:0] st,
                              logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    wait_idle();
    write_reg(REG_DEST_STRIDE, ds);
    write_reg(REG_DEST_LEFT, dl);
    write_reg(REG_DEST_TOP, dt);
    write_reg(REG_SOURCE_STRIDE, ss);
    write_reg(REG_SOURCE_LEFT, sl);
    write_reg(REG_SOURCE_TOP, st);
    write_reg(REG_RECT_WIDTH, w);
    write_reg(REG_RECT_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
    cur_w = eff_dim(w);
    cur_h = eff_dim(h);
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] fg, logic [PIX_W-1:0] bg);
    int gap;
    gap = src_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.fg_pixel <= fg;
    pix_ch.bg_pixel <= bg;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  task automatic stream_pixels(int n);
    logic [PIX_W-1:0] fg;
    repeat (n) begin
      fg = 16'($urandom);
      // lean on fully transparent and fully opaque alpha
      case ($urandom_range(0, 7))
        0:       fg[15:12] = 4'h0;
        1:       fg[15:12] = 4'hF;
        default: ;
      endcase
      send_pixel(fg, 16'($urandom));
    end
    pix_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [PIX_W-1:0] dir_fg [12] = '{16'h0000, 16'hFFFF, 16'hF000, 16'h0FFF, 16'h0FFF,
                                      16'hF000, 16'h8A5C, 16'h7777, 16'h1F0F, 16'hE0F0,
                                      16'hFFFF, 16'h0000};
    logic [PIX_W-1:0] dir_bg [12] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                      16'h0000, 16'h1234, 16'hAAAA, 16'h5555, 16'hFFFF,
                                      16'hFFFF, 16'h0000};
    int n;

    rst             <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_DEST_STRIDE;
    cfg_ch.data     <= '0;
    pix_ch.valid    <= 1'b0;
    pix_ch.fg_pixel <= '0;
    pix_ch.bg_pixel <= '0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset config: 1x1 rectangle, every pixel is the last one
    foreach (dir_fg[i]) send_pixel(dir_fg[i], dir_bg[i]);
    pix_ch.valid <= 1'b0;

    // all-ones strides and positions: positions mask to 1023, addresses wrap
    program_rect(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'd3, 11'd2);
    stream_pixels(8);
    // zero strides, zero dims taken as 1
    program_rect('0, '0, '0, '0, '0, '0, '0, '0);
    stream_pixels(3);

    // width above MAX_DIM clamps; full column range
    program_rect(pick_stride(), pick_pos(), pick_pos(), pick_stride(), pick_pos(), pick_pos(),
                 11'h7FF, 11'd0);
    stream_pixels(1026);
    // height above MAX_DIM clamps; full row range
    sink_gaps = 1'b0;
    program_rect(pick_stride(), pick_pos(), pick_pos(), pick_stride(), pick_pos(), pick_pos(),
                 11'd0, 11'd1025);
    stream_pixels(1026);

    repeat (30) begin
      src_gaps  = $urandom_range(0, 3) != 0;
      sink_gaps = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 4) == 0) begin
        // single write mid-rectangle restarts the raster
        wait_idle();
        write_reg(REG_DEST_LEFT, pick_pos());
        cfg_ch.valid <= 1'b0;
      end else begin
        program_rect(pick_stride(), pick_pos(), pick_pos(), pick_stride(), pick_pos(),
                     pick_pos(), pick_dim(), pick_dim());
      end
      n = cur_w * cur_h * $urandom_range(1, 2) + $urandom_range(0, 4);
      if (n > 60) n = 60;
      stream_pixels(n);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
